FILE: hdl/polar_cartesian_vector_unit_defines.svh
// ---------------------------------------------------------------------------
// polar_cartesian_vector_unit defines
// assertion macros shared by the vector unit
// ---------------------------------------------------------------------------
`ifndef POLAR_CARTESIAN_VECTOR_UNIT_DEFINES_SVH
`define POLAR_CARTESIAN_VECTOR_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define PCV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector unit check failed");

// next-cycle implication under reset
`define PCV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector unit check failed");

`endif

FILE: hdl/pcv_pkg.sv
// ---------------------------------------------------------------------------
// pcv_pkg
// shared types, constants and tables of the vector unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pcv_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = 68;

    localparam logic [2:0] FN_SET     = 3'd0;
    localparam logic [2:0] FN_ADD     = 3'd1;
    localparam logic [2:0] FN_ROT_BY  = 3'd2;
    localparam logic [2:0] FN_ROT_TO  = 3'd3;
    localparam logic [2:0] FN_SCALE   = 3'd4;
    localparam logic [2:0] FN_UNIT    = 3'd5;

    localparam logic signed [31:0] INV_GAIN     = 32'sh4DBA76D4;
    localparam logic [31:0]        QUARTER_TURN = 32'h40000000;
    localparam logic [31:0]        HALF_TURN    = 32'h80000000;

    typedef struct packed {
        logic                        start;
        logic signed [MUL_A_W-1:0]   mcand;
        logic signed [MUL_B_W-1:0]   mplier;
    } mul_req_t;

    typedef struct packed {
        logic                load;
        logic                vec_mode;
        logic signed [63:0]  x;
        logic signed [63:0]  y;
        logic signed [33:0]  z;
    } cor_req_t;

    // atan(2^-i) as binary angle
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [MUL_P_W-1:0] v);
        logic signed [31:0] r;
        if ((v[MUL_P_W-1:31] != '0) && (v[MUL_P_W-1:31] != '1))
            r = v[MUL_P_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/pcv_cmd_if.sv
// ---------------------------------------------------------------------------
// pcv_cmd_if
// command channel: func code and two operands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface pcv_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

FILE: hdl/pcv_res_if.sv
// ---------------------------------------------------------------------------
// pcv_res_if
// result channel: cartesian and polar form of the vector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface pcv_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] length;
    logic signed [31:0] heading;

    modport source (output valid, coord_x, coord_y, length, heading, input ready);
    modport sink   (input valid, coord_x, coord_y, length, heading, output ready);
endinterface
`default_nettype wire

FILE: hdl/pcv_serial_mul.sv
// ---------------------------------------------------------------------------
// pcv_serial_mul
// bit-serial signed multiplier, one multiplier bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcv_serial_mul (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  pcv_pkg::mul_req_t                        req,
    output logic                                     busy,
    output logic                                     done,
    output logic signed [pcv_pkg::MUL_P_W-1:0]       prod
);
    localparam int CW = $clog2(pcv_pkg::MUL_B_W);

    logic signed [pcv_pkg::MUL_P_W-1:0] acc_reg, acc_next;
    logic signed [pcv_pkg::MUL_P_W-1:0] mc_reg, mc_next;
    logic [pcv_pkg::MUL_B_W-1:0]        mp_reg, mp_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic                               last;

    assign last = (cnt_reg == CW'(pcv_pkg::MUL_B_W - 1));

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            mc_next   = pcv_pkg::MUL_P_W'(req.mcand);
            mp_next   = req.mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // sign bit of the multiplier carries negative weight
            if (mp_reg[0])
                acc_next = last ? acc_reg - mc_reg : acc_reg + mc_reg;
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

FILE: hdl/pcv_cordic.sv
// ---------------------------------------------------------------------------
// pcv_cordic
// iterative cordic, one micro-rotation per cycle, vectoring or rotation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcv_cordic #(
    parameter int CORDIC_STEPS = pcv_pkg::CORDIC_STEPS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  pcv_pkg::cor_req_t         req,
    output logic                      busy,
    output logic                      done,
    output logic signed [63:0]        x,
    output logic signed [63:0]        y,
    output logic signed [33:0]        z
);
    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [63:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [33:0] z_reg, z_next, at;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               vec_reg, vec_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               sel;

    always_comb
    begin
        dx  = y_reg >>> idx_reg;
        dy  = x_reg >>> idx_reg;
        at  = {2'b00, pcv_pkg::atan_turn(5'(idx_reg))};
        // vectoring drives y to zero, rotation drives z to zero
        sel = vec_reg ? !y_reg[63] : z_reg[33];

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        idx_next  = idx_reg;
        vec_next  = vec_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.load)
        begin
            x_next    = req.x;
            y_next    = req.y;
            z_next    = req.z;
            vec_next  = req.vec_mode;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sel)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            vec_reg  <= vec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
endmodule
`default_nettype wire

FILE: hdl/polar_cartesian_vector_unit.sv
// ---------------------------------------------------------------------------
// polar_cartesian_vector_unit
// one 2d vector kept in cartesian and polar form
// ---------------------------------------------------------------------------
// The unit holds one vector as x, y (signed Q16.16) and as length (signed
// Q16.16, saturating) and heading (32-bit binary angle, a full turn is 2^32).
// Each command item sets or offsets x, y (then length and heading follow
// from a cordic vectoring pass and a gain multiply) or changes the heading or
// length (then x, y follow from a gain multiply and a cordic rotation pass).
// Every command gives exactly one result item with all four values. One
// command is worked at a time: a multiply runs in the bit-serial multiplier
// and a cordic pass runs in the shared iteration unit. A zero vector after
// set/offset skips the cordic pass and the multiply, and unused func codes
// go straight to the hand-over. A new command is taken while the last
// result still waits in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "polar_cartesian_vector_unit_defines.svh"
module polar_cartesian_vector_unit #(
    parameter int FRAC_BITS    = pcv_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = pcv_pkg::CORDIC_STEPS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    pcv_cmd_if.sink      cmd,
    pcv_res_if.source    res
);
    localparam int PW = pcv_pkg::MUL_P_W;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCALE = 8'b0000_0010,   // magnitude times factor
        ST_GAIN  = 8'b0000_0100,   // magnitude times inverse gain
        ST_ROT   = 8'b0000_1000,   // cordic rotation pass
        ST_VPREP = 8'b0001_0000,   // quadrant fold before vectoring
        ST_VEC   = 8'b0010_0000,   // cordic vectoring pass
        ST_LEN   = 8'b0100_0000,   // vectored x times inverse gain
        ST_FIN   = 8'b1000_0000    // hand the item to the output register
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [31:0] mag_reg, mag_next;
    logic [31:0]        dir_reg, dir_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_x_reg, out_y_reg, out_len_reg, out_head_reg;

    pcv_pkg::mul_req_t  mul_req;
    pcv_pkg::cor_req_t  cor_req;
    logic               mul_busy, mul_done, cor_busy, cor_done;
    logic signed [PW-1:0] mul_prod;
    logic signed [63:0] cor_x, cor_y;
    logic signed [33:0] cor_z;

    logic               accept, fin_go;
    logic signed [31:0] unit_len, scaled;
    logic [31:0]        dir_adj, dir_fold;
    logic               flip;
    logic signed [63:0] gain_x;
    logic signed [63:0] vx, vy;
    logic signed [33:0] vz;

    assign accept   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign fin_go   = (state_reg == ST_FIN) && (!out_valid_reg || res.ready);
    assign unit_len = 32'(64'sd1 <<< FRAC_BITS);

    // rounding and clamping of the scale product
    assign scaled = pcv_pkg::sat32((mul_prod + (PW'(1) <<< (FRAC_BITS - 1)))
                                   >>> FRAC_BITS);

    // fold heading into the right half plane for rotation
    assign dir_adj  = dir_reg + pcv_pkg::QUARTER_TURN;
    assign flip     = dir_adj[31];
    assign dir_fold = flip ? dir_reg - pcv_pkg::HALF_TURN : dir_reg;
    assign gain_x   = flip ? -mul_prod[63:0] : mul_prod[63:0];

    // fold left half plane onto the right before vectoring
    always_comb
    begin
        vx = 64'(pos_x_reg);
        vy = 64'(pos_y_reg);
        vz = '0;
        if (pos_x_reg[31])
        begin
            if (!pos_y_reg[31])
            begin
                vx = 64'(pos_y_reg);
                vy = -64'(pos_x_reg);
                vz = 34'(pcv_pkg::QUARTER_TURN);
            end
            else
            begin
                vx = -64'(pos_y_reg);
                vy = 64'(pos_x_reg);
                vz = -34'(pcv_pkg::QUARTER_TURN);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        mag_next       = mag_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg;
        if (res.valid && res.ready)
            out_valid_next = 1'b0;

        mul_req.start  = 1'b0;
        mul_req.mcand  = pcv_pkg::MUL_A_W'(mag_reg);
        mul_req.mplier = pcv_pkg::INV_GAIN;

        cor_req.load     = 1'b0;
        cor_req.vec_mode = 1'b0;
        cor_req.x        = gain_x;
        cor_req.y        = '0;
        cor_req.z        = {{2{dir_fold[31]}}, dir_fold};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.func)
                        pcv_pkg::FN_SET:
                        begin
                            pos_x_next = cmd.operand_a;
                            pos_y_next = cmd.operand_b;
                            state_next = ST_VPREP;
                        end
                        pcv_pkg::FN_ADD:
                        begin
                            pos_x_next = pcv_pkg::sat32(PW'(pos_x_reg) + PW'(cmd.operand_a));
                            pos_y_next = pcv_pkg::sat32(PW'(pos_y_reg) + PW'(cmd.operand_b));
                            state_next = ST_VPREP;
                        end
                        pcv_pkg::FN_ROT_BY:
                        begin
                            dir_next      = dir_reg + cmd.operand_a;
                            mul_req.start = 1'b1;
                            state_next    = ST_GAIN;
                        end
                        pcv_pkg::FN_ROT_TO:
                        begin
                            dir_next      = cmd.operand_a;
                            mul_req.start = 1'b1;
                            state_next    = ST_GAIN;
                        end
                        pcv_pkg::FN_SCALE:
                        begin
                            mul_req.mplier = cmd.operand_a;
                            mul_req.start  = 1'b1;
                            state_next     = ST_SCALE;
                        end
                        pcv_pkg::FN_UNIT:
                        begin
                            mag_next      = unit_len;
                            dir_next      = cmd.operand_a;
                            mul_req.mcand = pcv_pkg::MUL_A_W'(unit_len);
                            mul_req.start = 1'b1;
                            state_next    = ST_GAIN;
                        end
                        default:
                            state_next = ST_FIN;
                    endcase
                end
            end
            ST_SCALE:
            begin
                if (mul_done)
                begin
                    mag_next      = scaled;
                    mul_req.mcand = pcv_pkg::MUL_A_W'(scaled);
                    mul_req.start = 1'b1;
                    state_next    = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                if (mul_done)
                begin
                    cor_req.load = 1'b1;
                    state_next   = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (cor_done)
                begin
                    pos_x_next = pcv_pkg::sat32((PW'(cor_x) + PW'(64'sh40000000)) >>> 31);
                    pos_y_next = pcv_pkg::sat32((PW'(cor_y) + PW'(64'sh40000000)) >>> 31);
                    state_next = ST_FIN;
                end
            end
            ST_VPREP:
            begin
                if ((pos_x_reg == '0) && (pos_y_reg == '0))
                begin
                    // zero vector has no heading
                    mag_next   = '0;
                    dir_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    cor_req.load     = 1'b1;
                    cor_req.vec_mode = 1'b1;
                    cor_req.x        = vx;
                    cor_req.y        = vy;
                    cor_req.z        = vz;
                    state_next       = ST_VEC;
                end
            end
            ST_VEC:
            begin
                if (cor_done)
                begin
                    dir_next      = cor_z[31:0];
                    mul_req.mcand = cor_x[pcv_pkg::MUL_A_W-1:0];
                    mul_req.start = 1'b1;
                    state_next    = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (mul_done)
                begin
                    mag_next   = pcv_pkg::sat32((mul_prod + PW'(64'sh40000000)) >>> 31);
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            mag_reg       <= '0;
            dir_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            mag_reg       <= mag_next;
            dir_reg       <= dir_next;
        end
    end

    // result payload, loaded when the item is handed over
    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_x_reg    <= pos_x_reg;
            out_y_reg    <= pos_y_reg;
            out_len_reg  <= mag_reg;
            out_head_reg <= dir_reg;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.coord_x = out_x_reg;
    assign res.coord_y = out_y_reg;
    assign res.length  = out_len_reg;
    assign res.heading = out_head_reg;

    pcv_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pcv_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .busy  (cor_busy),
        .done  (cor_done),
        .x     (cor_x),
        .y     (cor_y),
        .z     (cor_z)
    );

    // engines are quiet whenever a new item may enter
    `PCV_ASSERT_NOW(a_idle_quiet, cmd.ready, !mul_busy && !cor_busy)
    // a finished product only arrives in a multiply state
    `PCV_ASSERT_NOW(a_mul_state, mul_done,
        (state_reg == ST_SCALE) || (state_reg == ST_GAIN) || (state_reg == ST_LEN))
    // a finished cordic pass only arrives in a cordic state
    `PCV_ASSERT_NOW(a_cor_state, cor_done, (state_reg == ST_ROT) || (state_reg == ST_VEC))
    // an accepted item always leaves idle
    `PCV_ASSERT_NEXT(a_leave_idle, accept, state_reg != ST_IDLE)
endmodule
`default_nettype wire

FILE: verif/polar_cartesian_vector_unit_tb.sv
// ---------------------------------------------------------------------------
// polar_cartesian_vector_unit_tb
// checks every result item of the vector unit against a built-in predictor
// ---------------------------------------------------------------------------
// A driver and a monitor run as clocked always blocks. The driver takes its
// items from a queue that the initial block fills in phases with different
// idling on the command and result sides. Each accepted command is run
// through a bit-true predictor of the vectoring and rotation passes. Each
// accepted result is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module polar_cartesian_vector_unit_tb;

    localparam int FRAC      = 16;
    localparam int STEPS     = 24;
    localparam int MAX_CYC   = 1500000;
    localparam int DRAIN_CYC = 200;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] op_a;
        logic signed [31:0] op_b;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] len;
        logic        [31:0] hdg;
    } vec_state_t;

    logic clk;
    logic rst_n;

    pcv_cmd_if cmd ();
    pcv_res_if res ();

    polar_cartesian_vector_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    // model copy of the vector
    vec_state_t vec_model;

    cmd_item_t  pending_cmds[$];
    vec_state_t expected_vecs[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int results_seen;
    int cycle_count;
    int funcs_sent[8];

    always #10 clk = ~clk;

    // arctangent table as binary angles
    function automatic logic [31:0] atan_ang(input int i);
        logic [31:0] t [0:31];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
              32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
              32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -96'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // cartesian to polar: vectoring pass then gain removal
    function automatic void vectoring(inout vec_state_t v);
        logic signed [63:0] x, y, t, dx, dy;
        logic [31:0]        z;
        logic [95:0]        prod;
        x = 64'(v.x);
        y = 64'(v.y);
        z = '0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = pcv_pkg::QUARTER_TURN;
            end
            else
            begin
                x = -y; y = t; z = -pcv_pkg::QUARTER_TURN;
            end
        end
        if (x == 0 && y == 0)
        begin
            v.len = '0;
            v.hdg = '0;
            return;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + atan_ang(i);
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - atan_ang(i);
            end
        end
        // x is nonnegative here
        prod = (96'(x) * 96'(32'h4DBA76D4) + 96'h40000000) >> 31;
        v.len = (prod > 96'h7FFFFFFF) ? 32'sh7FFFFFFF : prod[31:0];
        v.hdg = z;
    endfunction

    // polar to cartesian: gain premultiply then rotation pass
    function automatic void rotation(inout vec_state_t v);
        logic signed [95:0] x, y, z, dx, dy;
        logic [31:0]        a;
        x = 96'(v.len) * 96'sh4DBA76D4;
        y = '0;
        a = v.hdg;
        if (((a + pcv_pkg::QUARTER_TURN) & pcv_pkg::HALF_TURN) != 0)
        begin
            x = -x;
            a = a - pcv_pkg::HALF_TURN;
        end
        z = 96'($signed(a));
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - 96'(atan_ang(i));
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + 96'(atan_ang(i));
            end
        end
        v.x = clamp32((x + 96'sh40000000) >>> 31);
        v.y = clamp32((y + 96'sh40000000) >>> 31);
    endfunction

    // apply one command to the model and return the vector it yields
    function automatic vec_state_t next_vector(input cmd_item_t c);
        logic signed [95:0] p;
        case (c.func)
            pcv_pkg::FN_SET:
            begin
                vec_model.x = c.op_a;
                vec_model.y = c.op_b;
                vectoring(vec_model);
            end
            pcv_pkg::FN_ADD:
            begin
                vec_model.x = clamp32(96'(vec_model.x) + 96'(c.op_a));
                vec_model.y = clamp32(96'(vec_model.y) + 96'(c.op_b));
                vectoring(vec_model);
            end
            pcv_pkg::FN_ROT_BY:
            begin
                vec_model.hdg = vec_model.hdg + c.op_a;
                rotation(vec_model);
            end
            pcv_pkg::FN_ROT_TO:
            begin
                vec_model.hdg = c.op_a;
                rotation(vec_model);
            end
            pcv_pkg::FN_SCALE:
            begin
                p = 96'(vec_model.len) * 96'(c.op_a) + (96'sd1 <<< (FRAC - 1));
                vec_model.len = clamp32(p >>> FRAC);
                rotation(vec_model);
            end
            pcv_pkg::FN_UNIT:
            begin
                vec_model.len = 32'sd1 <<< FRAC;
                vec_model.hdg = c.op_a;
                rotation(vec_model);
            end
            default:
            begin
            end
        endcase
        return vec_model;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            3, 4: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
            5, 6: return $signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(input logic [2:0] f, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        cmd_item_t c;
        c.func = f;
        c.op_a = a;
        c.op_b = b;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(input int n);
        int r;
        logic [2:0] f;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            // mostly valid funcs, a few unused codes
            if (r < 96)
                f = 3'($urandom_range(0, 5));
            else
                f = 3'($urandom_range(6, 7));
            // scale factors near unity keep the length from pinning at the rails
            if (f == pcv_pkg::FN_SCALE && $urandom_range(0, 3) != 0)
                queue_cmd(f, $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000,
                          $urandom);
            else
                queue_cmd(f, rand_operand(), rand_operand());
        end
    endtask

    task automatic drain_phase();
        while (pending_cmds.size() != 0 || expected_vecs.size() != 0)
            @(posedge clk);
    endtask

    // driver: presents the head of the pending queue, holds until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid     <= 1'b0;
            cmd.func      <= '0;
            cmd.operand_a <= '0;
            cmd.operand_b <= '0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                expected_vecs.push_back(next_vector({cmd.func, cmd.operand_a,
                                                     cmd.operand_b}));
                funcs_sent[cmd.func]++;
                void'(pending_cmds.pop_front());
            end
            if ((!cmd.valid || cmd.ready) && pending_cmds.size() > 0 &&
                !(cmd.valid && cmd.ready && pending_cmds.size() == 1) &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                // the next item is the head after any pop above
                cmd.valid     <= 1'b1;
                cmd.func      <= pending_cmds[0].func;
                cmd.operand_a <= pending_cmds[0].op_a;
                cmd.operand_b <= pending_cmds[0].op_b;
            end
            else if (cmd.ready || !cmd.valid)
                cmd.valid <= 1'b0;
        end
    end

    // monitor: checks accepted results, drives a randomly stalling ready
    always @(posedge clk or negedge rst_n)
    begin
        vec_state_t want;
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (expected_vecs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item x=%h y=%h len=%h hdg=%h",
                                 res.coord_x, res.coord_y, res.length, res.heading);
                end
                else
                begin
                    want = expected_vecs.pop_front();
                    if (res.coord_x !== want.x || res.coord_y !== want.y ||
                        res.length !== want.len || res.heading !== want.hdg)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("item %0d: exp x=%h y=%h len=%h hdg=%h got x=%h y=%h len=%h hdg=%h",
                                     results_seen, want.x, want.y, want.len, want.hdg,
                                     res.coord_x, res.coord_y, res.length, res.heading);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYC)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        results_seen   = 0;
        cycle_count    = 0;
        vec_model      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every func, zero vector, saturation, unused codes
        queue_cmd(pcv_pkg::FN_SET, 32'sd0, 32'sd0);
        queue_cmd(pcv_pkg::FN_SET, 32'sh00030000, 32'sh00040000);
        queue_cmd(pcv_pkg::FN_SET, -32'sh00030000, 32'sh00040000);
        queue_cmd(pcv_pkg::FN_SET, -32'sh00030000, -32'sh00040000);
        queue_cmd(pcv_pkg::FN_SET, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        queue_cmd(pcv_pkg::FN_SET, 32'sh80000000, 32'sh80000000);
        queue_cmd(pcv_pkg::FN_ADD, 32'sh80000000, 32'sh80000000);
        queue_cmd(pcv_pkg::FN_SET, 32'sh7FFFFFFF, 32'sh80000000);
        queue_cmd(pcv_pkg::FN_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        queue_cmd(pcv_pkg::FN_UNIT, 32'sh40000000, 32'sh7FFFFFFF);
        queue_cmd(pcv_pkg::FN_ROT_BY, 32'sh80000000, 32'sd0);
        queue_cmd(pcv_pkg::FN_ROT_BY, 32'sh7FFFFFFF, 32'sd0);
        queue_cmd(pcv_pkg::FN_ROT_TO, 32'sh80000000, 32'sd0);
        queue_cmd(pcv_pkg::FN_ROT_TO, 32'shC0000000, 32'sd0);
        queue_cmd(pcv_pkg::FN_SCALE, 32'sh7FFFFFFF, 32'sd0);
        queue_cmd(pcv_pkg::FN_SCALE, 32'sh7FFFFFFF, 32'sd0);
        queue_cmd(pcv_pkg::FN_SCALE, -32'sh00010000, 32'sd0);
        queue_cmd(pcv_pkg::FN_ROT_BY, 32'sh20000000, 32'sd0);
        queue_cmd(pcv_pkg::FN_SCALE, 32'sh80000000, 32'sd0);
        queue_cmd(pcv_pkg::FN_SCALE, 32'sd0, 32'sd0);
        queue_cmd(3'd6, 32'sh12345678, 32'sh7FFFFFFF);
        queue_cmd(3'd7, 32'sh80000000, 32'sh80000000);
        queue_cmd(pcv_pkg::FN_ADD, 32'sh00010000, 32'sd0);
        queue_cmd(pcv_pkg::FN_ADD, 32'sd0, 32'sd0);
        drain_phase();

        // random phases with different idling
        queue_random(300);
        drain_phase();
        send_idle_pct = 63;
        queue_random(280);
        drain_phase();
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        queue_random(280);
        drain_phase();
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        queue_random(270);
        drain_phase();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYC) @(posedge clk);

        $display("%0d result items checked: set %0d, add %0d, rotate by %0d, rotate to %0d",
                 results_seen, funcs_sent[0], funcs_sent[1], funcs_sent[2], funcs_sent[3]);
        $display("scale %0d, unit %0d, unused codes %0d, mismatches %0d",
                 funcs_sent[4], funcs_sent[5], funcs_sent[6] + funcs_sent[7], mismatches);
        if (mismatches == 0 && expected_vecs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
